// ----- src/gra_pkg.sv -----
// Shared types and constants for the greedy ratio assignment block.
`default_nettype none
package gra_pkg;

    // Field widths fixed by the word formats
    localparam int RATIO_W = 16;
    localparam int IDX_W   = 4;
    localparam int SLOTS   = 16;
    localparam int CNT_W   = 5;

    typedef logic [RATIO_W-1:0] t_ratio;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;

    // Control from the sequencer to the shared compare unit
    typedef struct packed {
        logic clear;   // start of a round: forget the current best
        logic valid;   // the cell at (row, col) is free and takes part
        t_idx row;
        t_idx col;
    } t_scan_ctl;

    // Running best cell of the current round
    typedef struct packed {
        logic   found;
        t_ratio gap;
        t_idx   row;
        t_idx   col;
    } t_best;

endpackage
`default_nettype wire

// ----- src/gra_pair_store.sv -----
// Image and frame ratio storage: one write port, one registered read port per store.
`default_nettype none
module gra_pair_store (
    input  wire                logic i_clk,
    input  wire                logic i_wr_en,
    input  wire  gra_pkg::t_idx      i_wr_addr,
    input  wire  gra_pkg::t_ratio    i_image,
    input  wire  gra_pkg::t_ratio    i_frame,
    input  wire  gra_pkg::t_idx      i_rd_row,
    input  wire  gra_pkg::t_idx      i_rd_col,
    output gra_pkg::t_ratio          o_image,
    output gra_pkg::t_ratio          o_frame
);
    import gra_pkg::*;

    t_ratio r_image [SLOTS];
    t_ratio r_frame [SLOTS];
    t_ratio r_rd_image;
    t_ratio r_rd_frame;

    // Load one pair per accepted word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_image[i_wr_addr] <= i_image;
            r_frame[i_wr_addr] <= i_frame;
        end
    end

    // Row selects the image, column selects the frame; data lands in the next cycle
    always_ff @(posedge i_clk) begin
        r_rd_image <= r_image[i_rd_row];
        r_rd_frame <= r_frame[i_rd_col];
    end

    assign o_image = r_rd_image;
    assign o_frame = r_rd_frame;

endmodule
`default_nettype wire

// ----- src/gra_min_unit.sv -----
// Shared distance and compare unit: one cell per cycle, keeps the round's best.
`default_nettype none
module gra_min_unit (
    input  wire                 logic i_clk,
    input  wire                 logic i_rst_n,
    input  wire  gra_pkg::t_scan_ctl  i_ctl,
    input  wire  gra_pkg::t_ratio     i_image,
    input  wire  gra_pkg::t_ratio     i_frame,
    output gra_pkg::t_best            o_best
);
    import gra_pkg::*;

    logic   r_found;
    t_ratio r_gap;
    t_idx   r_row;
    t_idx   r_col;
    t_ratio gap;
    logic   take;

    // Absolute difference, exact in 16 bits
    assign gap = (i_image > i_frame) ? (i_image - i_frame) : (i_frame - i_image);
    // Strict less-than keeps the first cell on ties
    assign take = i_ctl.valid && (!r_found || (gap < r_gap));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // Payload of the best cell
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_gap <= gap;
            r_row <= i_ctl.row;
            r_col <= i_ctl.col;
        end
    end

    assign o_best.found = r_found;
    assign o_best.gap   = r_gap;
    assign o_best.row   = r_row;
    assign o_best.col   = r_col;

endmodule
`default_nettype wire

// ----- src/greedy_ratio_assignment_unit.sv -----
// Top level: load sequencer, greedy scan control, assignment table, result register.
//
//  channel  dir  tdata bits                                  tlast
//  s_axis   in   [15:0] image_ratio, [31:16] frame_ratio      last
//  m_axis   out  [3:0] image_sel, [7:4] frame_sel             last_result
//
// Loading accepts one word per cycle. A word with tlast starts the assignment:
// N rounds, each issuing all N*N cells in turn to one shared distance/compare
// unit behind the registered store read, then a flush state for the last
// compare to land and a commit state, then N results at one per cycle when
// m_axis_tready is high.
// s_axis_tready is low from the tlast word until the final result is loaded.
// A low m_axis_tready holds the result word; the scan itself never stalls.
// Synchronous active-low reset clears the control state; stores are unset.
`default_nettype none
module greedy_ratio_assignment_unit #(
    parameter int MAX_ITEMS = 16
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  logic [31:0] s_axis_tdata,   // image_ratio, frame_ratio
    input  wire  logic        s_axis_tlast,   // last
    output logic              m_axis_tvalid,
    input  wire  logic        m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // image_sel, frame_sel
    output logic              m_axis_tlast    // last_result
);
    import gra_pkg::*;

    localparam int CAP_I = (MAX_ITEMS < SLOTS) ? MAX_ITEMS : SLOTS;
    localparam t_cnt CAP = CNT_W'(CAP_I);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]       r_state, n_state;
    t_cnt             r_cnt;
    t_cnt             r_round;
    logic [SLOTS-1:0] r_row, r_col;
    t_idx             r_i, r_j, r_emit;
    t_idx             r_assign [SLOTS];
    logic             r_cmp_valid;
    t_idx             r_cmp_row, r_cmp_col;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             r_out_last;

    t_scan_ctl scan_ctl;
    t_best     best;
    t_ratio    rd_image, rd_frame;
    t_idx      last_idx;
    t_cnt      round_inc;
    logic      in_acc, store_en, last_cell, out_load, emit_done, round_done;
    logic      cell_free;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign store_en  = in_acc && (r_cnt < CAP);
    assign last_idx  = IDX_W'(r_cnt - 5'd1);
    assign last_cell = (r_i == last_idx) && (r_j == last_idx);
    assign round_inc = r_round + 5'd1;
    assign round_done = (round_inc == r_cnt) || !best.found;
    assign out_load  = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);
    assign emit_done = out_load && (r_emit == last_idx);
    assign cell_free = (r_state == ST_SCAN) && !r_row[r_i] && !r_col[r_j];

    // Cell tag is registered alongside the store read so the two stay aligned
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= cell_free;
        end
        r_cmp_row <= r_i;
        r_cmp_col <= r_j;
    end

    // Scan control for the shared unit
    always_comb begin
        scan_ctl.row   = r_cmp_row;
        scan_ctl.col   = r_cmp_col;
        scan_ctl.valid = r_cmp_valid;
        scan_ctl.clear = (in_acc && s_axis_tlast) ||
                         ((r_state == ST_COMMIT) && !round_done);
    end

    gra_pair_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_en),
        .i_wr_addr (IDX_W'(r_cnt)),
        .i_image   (s_axis_tdata[15:0]),
        .i_frame   (s_axis_tdata[31:16]),
        .i_rd_row  (r_i),
        .i_rd_col  (r_j),
        .o_image   (rd_image),
        .o_frame   (rd_frame)
    );

    gra_min_unit u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_image (rd_image),
        .i_frame (rd_frame),
        .o_best  (best)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:   if (in_acc && s_axis_tlast) n_state = ST_SCAN;
            ST_SCAN:   if (last_cell) n_state = ST_FLUSH;
            ST_FLUSH:  n_state = ST_COMMIT;
            ST_COMMIT: n_state = round_done ? ST_EMIT : ST_SCAN;
            ST_EMIT:   if (emit_done) n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (store_en) r_cnt <= r_cnt + 5'd1;
            if ((r_state == ST_COMMIT) && best.found) begin
                r_row[best.row] <= 1'b1;
                r_col[best.col] <= 1'b1;
            end
            if (emit_done) begin
                r_cnt <= '0;
                r_row <= '0;
                r_col <= '0;
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // Scan position, round and emit counters
    always_ff @(posedge i_clk) begin
        if (scan_ctl.clear) begin
            r_i <= '0;
            r_j <= '0;
        end else if (r_state == ST_SCAN) begin
            if (r_j == last_idx) begin
                r_j <= '0;
                r_i <= r_i + 4'd1;
            end else begin
                r_j <= r_j + 4'd1;
            end
        end
        if (in_acc && s_axis_tlast) r_round <= '0;
        else if (r_state == ST_COMMIT) r_round <= round_inc;
        if (r_state == ST_COMMIT) r_emit <= '0;
        else if (out_load) r_emit <= r_emit + 4'd1;
    end

    // Assignment table
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_COMMIT) && best.found) r_assign[best.row] <= best.col;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {r_assign[r_emit], r_emit};
            r_out_last <= (r_emit == last_idx);
        end
    end

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

// ----- src/gra_checker.sv -----
// Port-level checks for the greedy ratio assignment block, bound to the top level.
`default_nettype none
module gra_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // A final input word starts the scan and closes the input side
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after final word");

    // While a non-final result is pending, the batch is still being reported
    a_emit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open during result emission");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind greedy_ratio_assignment_unit gra_checker u_gra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
